@@ src/jhsp_pkg.sv @@
// Package for the JPEG header and scan parser: parse phases, marker codes,
// status codes, result kinds and field widths. Used by jpeg_header_scan_parser.
`timescale 1ns / 1ps

package jhsp_pkg;

  localparam int LENGTH_BITS = 20;
  localparam int OUT_POS_W   = 20;
  localparam int DIM_W       = 16;

  typedef logic [LENGTH_BITS-1:0] pos_t;

  typedef enum logic [3:0] {
    PH_SOI0,
    PH_SOI1,
    PH_TOP,
    PH_FILL,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_DQT,
    PH_SOF,
    PH_SKIP,
    PH_SCAN,
    PH_IDLE
  } phase_t;

  localparam logic [7:0] MARK_FILL  = 8'hFF;
  localparam logic [7:0] MARK_SOI   = 8'hD8;
  localparam logic [7:0] MARK_EOI   = 8'hD9;
  localparam logic [7:0] MARK_DQT   = 8'hDB;
  localparam logic [7:0] MARK_SOF0  = 8'hC0;
  localparam logic [7:0] MARK_SOS   = 8'hDA;
  localparam logic [7:0] MARK_TEM   = 8'h01;
  localparam logic [7:0] MARK_RST0  = 8'hD0;
  localparam logic [7:0] MARK_RST7  = 8'hD7;
  localparam logic [7:0] SAMP_420   = 8'h22;

  localparam logic [7:0] QLEN_8BIT  = 8'd64;
  localparam logic [7:0] QLEN_16BIT = 8'd128;
  localparam logic [15:0] SOF_MIN_LEN = 16'd8;
  localparam int MIN_FRAME = 4;

  localparam logic [3:0] SOF_HEIGHT_HI = 4'd1;
  localparam logic [3:0] SOF_HEIGHT_LO = 4'd2;
  localparam logic [3:0] SOF_WIDTH_HI  = 4'd3;
  localparam logic [3:0] SOF_WIDTH_LO  = 4'd4;
  localparam logic [3:0] SOF_SAMPLING  = 4'd7;
  localparam logic [3:0] SOF_IDX_MAX   = 4'd15;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_SOI   = 3'd1;
  localparam logic [2:0] ST_BAD_LEN   = 3'd2;
  localparam logic [2:0] ST_TBL_OVER  = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;
  localparam logic [2:0] ST_MISSING   = 3'd5;
  localparam logic [2:0] ST_EMPTY     = 3'd6;

  localparam logic KIND_TABLE   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [6:0]           table_index;
    logic [7:0]           table_value;
    logic [2:0]           status;
    logic [DIM_W-1:0]     frame_width;
    logic [DIM_W-1:0]     frame_height;
    logic                 frame_type;
    logic [OUT_POS_W-1:0] scan_start;
    logic [OUT_POS_W-1:0] scan_length;
  } result_t;

endpackage

@@ src/jpeg_header_scan_parser.sv @@
// JPEG header and scan parser top level: one frame byte per transfer in,
// table writes and an end-of-frame summary out. Depends on jhsp_pkg.
//
//   channel | handshake               | payload
//   --------+-------------------------+------------------------------------------
//   byte    | byte_valid / byte_stall | data_byte, last_byte
//   result  | result_valid / _stall   | kind, table_index, table_value, status,
//           |                         | frame_width, frame_height, frame_type,
//           |                         | scan_start, scan_length
//
// One byte per cycle while byte_stall is low; each result is registered in the output or skid register.
// The parse step and the summary are short combinational logic into the output register.
// A skid register behind the output register absorbs one result under stall;
// byte_stall rises only while the skid register is full.
// Synchronous reset returns to the first SOI byte; so does every last byte.
`timescale 1ns / 1ps

module jpeg_header_scan_parser (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           byte_valid,
  output logic                           byte_stall,
  input  logic [7:0]                     data_byte,
  input  logic                           last_byte,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic                           kind,
  output logic [6:0]                     table_index,
  output logic [7:0]                     table_value,
  output logic [2:0]                     status,
  output logic [jhsp_pkg::DIM_W-1:0]     frame_width,
  output logic [jhsp_pkg::DIM_W-1:0]     frame_height,
  output logic                           frame_type,
  output logic [jhsp_pkg::OUT_POS_W-1:0] scan_start,
  output logic [jhsp_pkg::OUT_POS_W-1:0] scan_length
);
  import jhsp_pkg::*;

  phase_t      phase, phase_next;
  pos_t        byte_position, byte_position_next;
  logic [7:0]  current_marker, current_marker_next;
  logic [15:0] segment_remaining, segment_remaining_next;
  logic [7:0]  table_remaining, table_remaining_next;
  logic [1:0]  table_keep_id, table_keep_id_next;
  logic [3:0]  sof_byte_index, sof_byte_index_next;
  logic [15:0] width_reg, width_reg_next;
  logic [15:0] height_reg, height_reg_next;
  logic        type_reg, type_reg_next;
  logic [1:0]  table_mask, table_mask_next;
  pos_t        scan_start_reg, scan_start_reg_next;
  pos_t        eoi_position, eoi_position_next;
  logic        eoi_found, eoi_found_next;
  logic        previous_was_ff, previous_was_ff_next;
  logic [2:0]  error_code, error_code_next;
  pos_t        iteration_start, iteration_start_next;

  logic        accept;
  logic        is_standalone;
  logic [15:0] len_full, len_rem, seg_dec;
  logic [15:0] qlen;
  logic        len_bad, dqt_fail, sof_ok;
  phase_t      marker_phase, done_phase;

  logic        wr;
  logic [6:0]  w_index;
  result_t     res, out_reg, skid_reg;
  logic        res_valid, skid_valid, out_take;

  logic [LENGTH_BITS:0] ran_sum;
  logic        ran;
  pos_t        sum_start, sum_end, sum_length;
  logic [2:0]  sum_status;

  assign accept     = byte_valid && !byte_stall;
  assign byte_stall = skid_valid;
  assign out_take   = result_valid && !result_stall;

  assign byte_position_next = byte_position + pos_t'(1);
  assign is_standalone = (data_byte == MARK_TEM) ||
                         (data_byte >= MARK_RST0 && data_byte <= MARK_RST7);
  assign len_full = {segment_remaining[7:0], data_byte};
  assign len_bad  = len_full < 16'd2;
  assign len_rem  = len_full - 16'd2;
  assign seg_dec  = segment_remaining - 16'd1;
  assign qlen     = (data_byte[7:4] != 4'd0) ? {8'd0, QLEN_16BIT} : {8'd0, QLEN_8BIT};
  assign dqt_fail = qlen > seg_dec;
  assign sof_ok   = len_rem >= SOF_MIN_LEN;
  assign done_phase = (current_marker == MARK_SOS) ? PH_SCAN : PH_TOP;

  always_comb begin
    priority if (data_byte == MARK_FILL) begin
      marker_phase = PH_FILL;
    end else if (data_byte == MARK_EOI) begin
      marker_phase = PH_IDLE;
    end else if (is_standalone) begin
      marker_phase = PH_TOP;
    end else begin
      marker_phase = PH_LEN_HI;
    end
  end

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_SOI0: phase_next = (data_byte == MARK_FILL) ? PH_SOI1 : PH_IDLE;
      PH_SOI1: phase_next = (data_byte == MARK_SOI) ? PH_TOP : PH_IDLE;
      PH_TOP, PH_FILL: phase_next = marker_phase;
      PH_LEN_HI: phase_next = PH_LEN_LO;
      PH_LEN_LO: begin
        priority if (len_bad) begin
          phase_next = PH_IDLE;
        end else if (len_rem == 16'd0) begin
          phase_next = done_phase;
        end else if (current_marker == MARK_DQT) begin
          phase_next = PH_DQT;
        end else if (current_marker == MARK_SOF0 && sof_ok) begin
          phase_next = PH_SOF;
        end else begin
          phase_next = PH_SKIP;
        end
      end
      PH_DQT: begin
        priority if (table_remaining == 8'd0 && dqt_fail) begin
          phase_next = PH_IDLE;
        end else if (seg_dec == 16'd0) begin
          phase_next = done_phase;
        end else begin
          phase_next = PH_DQT;
        end
      end
      PH_SOF, PH_SKIP: begin
        if (seg_dec == 16'd0) begin
          phase_next = done_phase;
        end
      end
      PH_SCAN, PH_IDLE: phase_next = phase;
      default: phase_next = PH_IDLE;
    endcase
  end

  // datapath next values and table write
  always_comb begin
    current_marker_next    = current_marker;
    segment_remaining_next = segment_remaining;
    table_remaining_next   = table_remaining;
    table_keep_id_next     = table_keep_id;
    sof_byte_index_next    = sof_byte_index;
    width_reg_next         = width_reg;
    height_reg_next        = height_reg;
    type_reg_next          = type_reg;
    table_mask_next        = table_mask;
    scan_start_reg_next    = scan_start_reg;
    eoi_position_next      = eoi_position;
    eoi_found_next         = eoi_found;
    previous_was_ff_next   = previous_was_ff;
    error_code_next        = error_code;
    iteration_start_next   = iteration_start;
    wr                     = 1'b0;
    w_index                = {table_keep_id == 2'd2, 6'(8'd0 - table_remaining)};
    unique case (phase)
      PH_SOI0: if (data_byte != MARK_FILL) error_code_next = ST_BAD_SOI;
      PH_SOI1: if (data_byte != MARK_SOI) error_code_next = ST_BAD_SOI;
      PH_TOP, PH_FILL: begin
        if (phase == PH_TOP) iteration_start_next = byte_position;
        if (marker_phase == PH_LEN_HI) current_marker_next = data_byte;
      end
      PH_LEN_HI: segment_remaining_next = {8'd0, data_byte};
      PH_LEN_LO: begin
        if (len_bad) begin
          error_code_next = ST_BAD_LEN;
        end else begin
          segment_remaining_next = len_rem;
          if (current_marker == MARK_DQT) begin
            table_remaining_next = 8'd0;
            table_keep_id_next   = 2'd0;
          end else if (current_marker == MARK_SOF0 && sof_ok) begin
            sof_byte_index_next = 4'd0;
          end
        end
      end
      PH_DQT: begin
        segment_remaining_next = seg_dec;
        if (table_remaining == 8'd0) begin
          if (dqt_fail) begin
            error_code_next = ST_TBL_OVER;
          end else begin
            table_remaining_next = qlen[7:0];
            if (data_byte[7:4] == 4'd0 && data_byte[3:1] == 3'd0) begin
              table_keep_id_next = {1'b0, data_byte[0]} + 2'd1;
              table_mask_next    = table_mask | (data_byte[0] ? 2'b10 : 2'b01);
            end else begin
              table_keep_id_next = 2'd0;
            end
          end
        end else begin
          wr = table_keep_id != 2'd0;
          table_remaining_next = table_remaining - 8'd1;
        end
      end
      PH_SOF: begin
        segment_remaining_next = seg_dec;
        unique case (sof_byte_index)
          SOF_HEIGHT_HI: height_reg_next = {data_byte, height_reg[7:0]};
          SOF_HEIGHT_LO: height_reg_next = {height_reg[15:8], data_byte};
          SOF_WIDTH_HI:  width_reg_next  = {data_byte, width_reg[7:0]};
          SOF_WIDTH_LO:  width_reg_next  = {width_reg[15:8], data_byte};
          SOF_SAMPLING:  type_reg_next   = data_byte == SAMP_420;
          default: ;
        endcase
        if (sof_byte_index < SOF_IDX_MAX) sof_byte_index_next = sof_byte_index + 4'd1;
      end
      PH_SKIP: segment_remaining_next = seg_dec;
      PH_SCAN: begin
        if (previous_was_ff && data_byte == MARK_EOI) begin
          eoi_position_next = byte_position - pos_t'(1);
          eoi_found_next    = 1'b1;
        end
        previous_was_ff_next = data_byte == MARK_FILL;
      end
      PH_IDLE: ;
      default: ;
    endcase
    if (phase != PH_SCAN && phase_next == PH_SCAN) begin
      scan_start_reg_next  = byte_position_next;
      previous_was_ff_next = 1'b0;
      eoi_found_next       = 1'b0;
    end
  end

  // end-of-frame summary
  assign ran_sum = {1'b0, iteration_start_next} + (LENGTH_BITS+1)'(MIN_FRAME);
  assign ran     = ran_sum <= {1'b0, byte_position_next};
  assign sum_end = eoi_found_next ? eoi_position_next : byte_position_next;
  assign sum_length = sum_end - scan_start_reg_next;

  always_comb begin
    sum_start  = '0;
    sum_status = ST_MISSING;
    priority if (byte_position_next < pos_t'(MIN_FRAME) || error_code_next == ST_BAD_SOI) begin
      sum_status = ST_BAD_SOI;
    end else if (error_code_next != ST_OK) begin
      sum_status = ran ? error_code_next : ST_MISSING;
    end else if (phase_next == PH_SCAN) begin
      if (ran) begin
        sum_start = scan_start_reg_next;
        if (width_reg_next == 16'd0 || height_reg_next == 16'd0 ||
            table_mask_next != 2'b11) begin
          sum_status = ST_MISSING;
        end else begin
          sum_status = (sum_length == '0) ? ST_EMPTY : ST_OK;
        end
      end
    end else if (phase_next == PH_LEN_HI || phase_next == PH_LEN_LO ||
                 phase_next == PH_DQT || phase_next == PH_SOF ||
                 phase_next == PH_SKIP) begin
      sum_status = ran ? ST_TRUNC : ST_MISSING;
    end else begin
      sum_status = ST_MISSING;
    end
  end

  always_comb begin
    res = '0;
    res_valid = accept && (last_byte || wr);
    if (last_byte) begin
      res.kind         = KIND_SUMMARY;
      res.status       = sum_status;
      res.frame_width  = width_reg_next;
      res.frame_height = height_reg_next;
      res.frame_type   = type_reg_next;
      res.scan_start   = OUT_POS_W'(sum_start);
      res.scan_length  = (sum_status == ST_OK) ? OUT_POS_W'(sum_length) : '0;
    end else begin
      res.kind        = KIND_TABLE;
      res.table_index = w_index;
      res.table_value = data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      phase             <= PH_SOI0;
      byte_position     <= '0;
      current_marker    <= '0;
      segment_remaining <= '0;
      table_remaining   <= '0;
      table_keep_id     <= '0;
      sof_byte_index    <= '0;
      width_reg         <= '0;
      height_reg        <= '0;
      type_reg          <= 1'b0;
      table_mask        <= '0;
      scan_start_reg    <= '0;
      eoi_position      <= '0;
      eoi_found         <= 1'b0;
      previous_was_ff   <= 1'b0;
      error_code        <= ST_OK;
      iteration_start   <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      byte_position     <= byte_position_next;
      current_marker    <= current_marker_next;
      segment_remaining <= segment_remaining_next;
      table_remaining   <= table_remaining_next;
      table_keep_id     <= table_keep_id_next;
      sof_byte_index    <= sof_byte_index_next;
      width_reg         <= width_reg_next;
      height_reg        <= height_reg_next;
      type_reg          <= type_reg_next;
      table_mask        <= table_mask_next;
      scan_start_reg    <= scan_start_reg_next;
      eoi_position      <= eoi_position_next;
      eoi_found         <= eoi_found_next;
      previous_was_ff   <= previous_was_ff_next;
      error_code        <= error_code_next;
      iteration_start   <= iteration_start_next;
    end
  end

  // output register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (!result_valid || out_take) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) out_reg <= skid_reg;
    end else if (res_valid) begin
      if (!result_valid || out_take) begin
        out_reg <= res;
      end else begin
        skid_reg <= res;
      end
    end
  end

  assign kind         = out_reg.kind;
  assign table_index  = out_reg.table_index;
  assign table_value  = out_reg.table_value;
  assign status       = out_reg.status;
  assign frame_width  = out_reg.frame_width;
  assign frame_height = out_reg.frame_height;
  assign frame_type   = out_reg.frame_type;
  assign scan_start   = out_reg.scan_start;
  assign scan_length  = out_reg.scan_length;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid register full while output register empty");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && last_byte) |=> (phase == PH_SOI0 && byte_position == '0))
    else $error("parser did not restart after last byte");

  a_write_from_dqt: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !last_byte) |-> (phase == PH_DQT && table_keep_id != 2'd0))
    else $error("table write outside a kept DQT table");

  a_table_fields: assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind == KIND_TABLE) |-> (status == ST_OK && scan_length == '0))
    else $error("table write carries summary fields");

  a_ok_nonempty: assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind == KIND_SUMMARY && status == ST_OK) |-> (scan_length != '0))
    else $error("ok summary with empty scan");
`endif

endmodule
